/* sv/sor_pressure_poisson_solver_core_defines.svh */
// Assertion macros for the SOR pressure solver core.
// Used by the top level; expects clk and rst in scope.
`ifndef SOR_PRESSURE_POISSON_SOLVER_CORE_DEFINES_SVH
`define SOR_PRESSURE_POISSON_SOLVER_CORE_DEFINES_SVH

// same-cycle implication
`define SORP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SORP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/sorp_pkg.sv */
// Shared types, constants and saturation helper for the SOR solver core.
// No dependencies.
package sorp_pkg;

  localparam int DATA_W     = 32;
  localparam int RES_W      = 63;
  localparam int ITER_W     = 16;
  localparam int SIZE_W     = 6;
  localparam int COEF_W     = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 63;

  localparam logic [RES_W-1:0] RES_ONE = 63'h1_0000_0000;
  localparam logic [RES_W-1:0] RES_MAX = '1;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_SOLVE = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_COLS   = 3'd0,
    REG_GRID_ROWS   = 3'd1,
    REG_MAX_ITER    = 3'd2,
    REG_TOL_SQ      = 3'd3,
    REG_RELAX       = 3'd4,
    REG_INV_DX_SQ   = 3'd5,
    REG_INV_DY_SQ   = 3'd6,
    REG_SWEEP_ORDER = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    CAP_C = 3'd0,
    CAP_L = 3'd1,
    CAP_R = 3'd2,
    CAP_U = 3'd3,
    CAP_D = 3'd4
  } cap_t;

  typedef struct packed {
    logic [SIZE_W-1:0] grid_cols;
    logic [SIZE_W-1:0] grid_rows;
    logic [ITER_W-1:0] max_iterations;
    logic [RES_W-1:0]  tolerance_sq;
    logic [COEF_W-1:0] relax_factor;
    logic [COEF_W-1:0] inv_dx_sq;
    logic [COEF_W-1:0] inv_dy_sq;
    logic              sweep_order;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    grid_cols:      6'd62,
    grid_rows:      6'd62,
    max_iterations: 16'd1000,
    tolerance_sq:   63'd42950,
    relax_factor:   31'd65536,
    inv_dx_sq:      31'd65536,
    inv_dy_sq:      31'd65536,
    sweep_order:    1'b0
  };

  typedef struct packed {
    logic solve_init;
    logic sum_clr;
    logic rd_en;
    logic rd_ext;
    logic cap_en;
    cap_t cap_sel;
    logic mul1;
    logic sum_r;
    logic mul2;
    logic wb;
    logic acc;
    logic halo_we;
    logic load_we;
    logic div_start;
    logic div_take;
    logic finish;
    logic emit;
    logic emit_rd;
  } cmd_t;

  typedef struct packed {
    logic res_ge_tol;
    logic it_lt_limit;
    logic div_done;
  } sts_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [64:0] x);
    if (x > 65'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (x < -65'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return x[DATA_W-1:0];
    end
  endfunction

endpackage

/* sv/sorp_if.sv */
// Job and result channel interfaces of the SOR solver core.
// Depends on nothing; widths follow the item fields.
interface sorp_job_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [5:0]         col;
  logic [5:0]         row;
  logic signed [31:0] pressure_in;
  logic signed [31:0] source_in;
  modport source (output valid, func, col, row, pressure_in, source_in, input ready);
  modport sink (input valid, func, col, row, pressure_in, source_in, output ready);
endinterface

interface sorp_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pressure_out;
  logic [15:0]        iterations;
  logic [62:0]        residual;
  logic               converged;
  modport source (output valid, pressure_out, iterations, residual, converged, input ready);
  modport sink (input valid, pressure_out, iterations, residual, converged, output ready);
endinterface

/* sv/sorp_div.sv */
// Restoring divider, one quotient bit per cycle, for the mean residual.
// Depends on nothing.
module sorp_div #(
  parameter int DW = 63,
  parameter int VW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);
  localparam int CNTW = $clog2(DW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [VW-1:0]   rem;
  logic [DW-1:0]   quo;
  logic [VW:0]     trial;
  logic            fit;

  assign trial    = {rem, quo[DW-1]};
  assign fit      = trial >= {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(DW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fit ? VW'(trial - {1'b0, divisor}) : trial[VW-1:0];
      quo <= {quo[DW-2:0], fit};
    end
  end
endmodule

/* sv/sorp_dp.sv */
// Datapath: pressure and source stores, stencil arithmetic, residual sum and status.
// Depends on sorp_pkg and sorp_div.
module sorp_dp import sorp_pkg::*; #(
  parameter int MAX_COLS = 62,
  parameter int MAX_ROWS = 62,
  localparam int CW = $clog2(MAX_COLS + 2),
  localparam int RW = $clog2(MAX_ROWS + 2)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic [CW-1:0]            nc,
  input  logic [RW-1:0]            nr,
  input  logic [CW-1:0]            rcol,
  input  logic [RW-1:0]            rrow,
  input  logic [CW-1:0]            wcol,
  input  logic [RW-1:0]            wrow,
  input  logic [SIZE_W-1:0]        ext_col,
  input  logic [SIZE_W-1:0]        ext_row,
  input  logic signed [DATA_W-1:0] ext_pressure,
  input  logic signed [DATA_W-1:0] ext_source,
  output logic signed [DATA_W-1:0] pressure_out,
  output logic [ITER_W-1:0]        iterations,
  output logic [RES_W-1:0]         residual,
  output logic                     converged
);
  localparam int STRIDE = MAX_COLS + 2;
  localparam int DEPTH  = (MAX_COLS + 2) * (MAX_ROWS + 2);
  localparam int AW     = $clog2(DEPTH);
  localparam int NW     = $clog2(MAX_COLS * MAX_ROWS + 1);

  logic signed [DATA_W-1:0] pmem [DEPTH];
  logic signed [DATA_W-1:0] smem [DEPTH];
  logic signed [DATA_W-1:0] prd, srd;
  logic signed [DATA_W-1:0] pc, pl, pr, pu, pdn, src;
  logic signed [DATA_W-1:0] lapx, lapy, lap, delta, newp, r, pwdata;
  logic signed [33:0]       dx, dy;
  logic signed [63:0]       px, py, pdel, rsq;
  logic [RES_W-1:0]         rr, sum, res, quo, mean;
  logic [RES_W:0]           sum_s;
  logic [ITER_W-1:0]        it, sweep_cnt;
  logic [NW-1:0]            n;
  logic                     ext_in, pwe, swe, rd_inside, stop, div_done;
  logic [AW-1:0]            ext_addr, raddr, waddr;

  assign ext_in   = (32'(ext_col) < STRIDE) && (32'(ext_row) < MAX_ROWS + 2);
  assign ext_addr = ext_in ? AW'(32'(ext_row) * STRIDE + 32'(ext_col)) : '0;
  assign raddr    = cmd.rd_ext ? ext_addr : AW'(32'(rrow) * STRIDE + 32'(rcol));
  assign waddr    = cmd.load_we ? ext_addr : AW'(32'(wrow) * STRIDE + 32'(wcol));
  assign pwe      = (cmd.load_we && ext_in) || cmd.wb || cmd.halo_we;
  assign swe      = cmd.load_we && ext_in;

  always_comb begin
    if (cmd.load_we) begin
      pwdata = ext_pressure;
    end else if (cmd.wb) begin
      pwdata = newp;
    end else begin
      pwdata = prd;
    end
  end

  always_ff @(posedge clk) begin
    if (pwe) begin
      pmem[waddr] <= pwdata;
    end
    if (swe) begin
      smem[waddr] <= ext_source;
    end
    if (cmd.rd_en) begin
      prd <= pmem[raddr];
      srd <= smem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      case (cmd.cap_sel)
        CAP_C: begin
          pc  <= prd;
          src <= srd;
        end
        CAP_L: pl  <= prd;
        CAP_R: pr  <= prd;
        CAP_U: pu  <= prd;
        CAP_D: pdn <= prd;
        default: ;
      endcase
    end
  end

  assign dx    = 34'(pr) + 34'(pl) - (34'(pc) <<< 1);
  assign dy    = 34'(pdn) + 34'(pu) - (34'(pc) <<< 1);
  assign lapx  = sat32(65'(px >>> 16));
  assign lapy  = sat32(65'(py >>> 16));
  assign lap   = sat32(65'(lapx) + 65'(lapy));
  assign delta = sat32(65'(pdel >>> 16));
  assign newp  = sat32(65'(pc) - 65'(delta));
  assign rsq   = r * r;
  assign sum_s = {1'b0, sum} + {1'b0, rr};

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      px <= sat32(65'(dx)) * $signed({1'b0, cfg.inv_dx_sq});
      py <= sat32(65'(dy)) * $signed({1'b0, cfg.inv_dy_sq});
    end
    if (cmd.sum_r) begin
      r <= sat32(65'(src) - 65'(lap));
    end
    if (cmd.mul2) begin
      pdel <= r * $signed({1'b0, cfg.relax_factor});
    end
    if (cmd.wb) begin
      rr <= rsq[RES_W-1:0];
    end
    if (cmd.sum_clr) begin
      sum <= '0;
    end else if (cmd.acc) begin
      sum <= sum_s[RES_W] ? RES_MAX : sum_s[RES_W-1:0];
    end
    if (cmd.solve_init) begin
      n <= NW'(32'(nc) * 32'(nr));
    end
  end

  sorp_div #(
    .DW(RES_W),
    .VW(NW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum),
    .divisor  (n),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res       <= '0;
      it        <= '0;
      sweep_cnt <= '0;
      mean      <= '0;
      stop      <= 1'b0;
      rd_inside <= 1'b0;
    end else begin
      if (cmd.solve_init) begin
        res <= RES_ONE;
        it  <= '0;
      end else if (cmd.div_take) begin
        res <= quo;
        it  <= it + 1'b1;
      end
      if (cmd.finish) begin
        sweep_cnt <= it;
        mean      <= res;
        stop      <= !sts.res_ge_tol;
      end
      if (cmd.rd_ext) begin
        rd_inside <= ext_in;
      end
    end
  end

  assign sts.res_ge_tol  = res >= cfg.tolerance_sq;
  assign sts.it_lt_limit = it < cfg.max_iterations;
  assign sts.div_done    = div_done;

  assign pressure_out = (cmd.emit_rd && rd_inside) ? prd : '0;
  assign iterations   = sweep_cnt;
  assign residual     = mean;
  assign converged    = stop;
endmodule

/* sv/sorp_ctrl.sv */
// Controller: job decode, sweep and halo sequencing, divider and result control.
// Depends on sorp_pkg.
module sorp_ctrl import sorp_pkg::*; #(
  parameter int MAX_COLS = 62,
  parameter int MAX_ROWS = 62,
  localparam int CW = $clog2(MAX_COLS + 2),
  localparam int RW = $clog2(MAX_ROWS + 2)
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          job_valid,
  input  logic [1:0]    job_func,
  input  logic          slot_free,
  output logic          job_ready,
  output cmd_t          cmd,
  input  sts_t          sts,
  output logic [CW-1:0] nc,
  output logic [RW-1:0] nr,
  output logic [CW-1:0] rcol,
  output logic [RW-1:0] rrow,
  output logic [CW-1:0] wcol,
  output logic [RW-1:0] wrow
);
  typedef enum logic [14:0] {
    S_IDLE     = 15'b000_0000_0000_0001,
    S_READ     = 15'b000_0000_0000_0010,
    S_DONE     = 15'b000_0000_0000_0100,
    S_CHECK    = 15'b000_0000_0000_1000,
    S_SCAN     = 15'b000_0000_0001_0000,
    S_FETCH    = 15'b000_0000_0010_0000,
    S_MUL1     = 15'b000_0000_0100_0000,
    S_SUM      = 15'b000_0000_1000_0000,
    S_MUL2     = 15'b000_0001_0000_0000,
    S_WB       = 15'b000_0010_0000_0000,
    S_ACC      = 15'b000_0100_0000_0000,
    S_HALO_RD  = 15'b000_1000_0000_0000,
    S_HALO_WR  = 15'b001_0000_0000_0000,
    S_DIV_GO   = 15'b010_0000_0000_0000,
    S_DIV_WAIT = 15'b100_0000_0000_0000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] i, hsc, hdc;
  logic [RW-1:0] j, hsr, hdr;
  logic          pass;
  logic [2:0]    fstep;
  logic [1:0]    hkind;
  logic          accept, go, skip, halo_last;

  always_comb begin
    if (cfg.grid_cols == '0) begin
      nc = CW'(1);
    end else if (32'(cfg.grid_cols) > MAX_COLS) begin
      nc = CW'(MAX_COLS);
    end else begin
      nc = CW'(cfg.grid_cols);
    end
    if (cfg.grid_rows == '0) begin
      nr = RW'(1);
    end else if (32'(cfg.grid_rows) > MAX_ROWS) begin
      nr = RW'(MAX_ROWS);
    end else begin
      nr = RW'(cfg.grid_rows);
    end
  end

  assign job_ready = (state == S_IDLE) && slot_free;
  assign accept    = job_valid && job_ready;
  assign go        = sts.res_ge_tol && sts.it_lt_limit;
  assign skip      = cfg.sweep_order && ((i[0] ^ j[0]) != pass);
  assign halo_last = (hkind < 2'd2) ? (i == nc) : (j == nr);

  always_comb begin
    case (hkind)
      2'd0: begin
        hsc = i;  hsr = RW'(1);  hdc = i;          hdr = '0;
      end
      2'd1: begin
        hsc = i;  hsr = nr;      hdc = i;          hdr = nr + 1'b1;
      end
      2'd2: begin
        hsc = CW'(1); hsr = j;   hdc = '0;         hdr = j;
      end
      default: begin
        hsc = nc; hsr = j;       hdc = nc + 1'b1;  hdr = j;
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    rcol       = i;
    rrow       = j;
    wcol       = i;
    wrow       = j;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (func_t'(job_func))
            FUNC_LOAD: begin
              cmd.load_we = 1'b1;
              cmd.emit    = 1'b1;
            end
            FUNC_READ: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_ext = 1'b1;
              state_next = S_READ;
            end
            FUNC_SOLVE: begin
              cmd.solve_init = 1'b1;
              state_next     = S_CHECK;
            end
            default: cmd.emit = 1'b1;
          endcase
        end
      end
      S_READ: begin
        cmd.emit    = 1'b1;
        cmd.emit_rd = 1'b1;
        state_next  = S_IDLE;
      end
      S_CHECK: begin
        if (go) begin
          cmd.sum_clr = 1'b1;
          state_next  = S_SCAN;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        if (j > nr) begin
          if (!(cfg.sweep_order && !pass)) begin
            state_next = S_HALO_RD;
          end
        end else if (!skip) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.rd_en   = fstep < 3'd5;
        cmd.cap_en  = fstep != 3'd0;
        cmd.cap_sel = cap_t'(fstep - 3'd1);
        case (fstep)
          3'd1: rcol = i - 1'b1;
          3'd2: rcol = i + 1'b1;
          3'd3: rrow = j - 1'b1;
          3'd4: rrow = j + 1'b1;
          default: ;
        endcase
        if (fstep == 3'd5) begin
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum_r  = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_WB;
      end
      S_WB: begin
        cmd.wb     = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_SCAN;
      end
      S_HALO_RD: begin
        cmd.rd_en  = 1'b1;
        rcol       = hsc;
        rrow       = hsr;
        state_next = S_HALO_WR;
      end
      S_HALO_WR: begin
        cmd.halo_we = 1'b1;
        wcol        = hdc;
        wrow        = hdr;
        state_next  = (hkind == 2'd3 && halo_last) ? S_DIV_GO : S_HALO_RD;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = S_CHECK;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i     <= CW'(1);
      j     <= RW'(1);
      pass  <= 1'b0;
      fstep <= '0;
      hkind <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_CHECK: begin
          i    <= CW'(1);
          j    <= RW'(1);
          pass <= 1'b0;
        end
        S_SCAN: begin
          if (j > nr) begin
            i <= CW'(1);
            j <= RW'(1);
            if (cfg.sweep_order && !pass) begin
              pass <= 1'b1;
            end else begin
              hkind <= '0;
            end
          end else if (skip) begin
            if (i == nc) begin
              i <= CW'(1);
              j <= j + 1'b1;
            end else begin
              i <= i + 1'b1;
            end
          end else begin
            fstep <= '0;
          end
        end
        S_FETCH: fstep <= fstep + 1'b1;
        S_ACC: begin
          if (i == nc) begin
            i <= CW'(1);
            j <= j + 1'b1;
          end else begin
            i <= i + 1'b1;
          end
        end
        S_HALO_WR: begin
          if (hkind < 2'd2) begin
            if (i == nc) begin
              i     <= CW'(1);
              hkind <= hkind + 1'b1;
            end else begin
              i <= i + 1'b1;
            end
          end else begin
            if (j == nr) begin
              j     <= RW'(1);
              hkind <= hkind + 1'b1;
            end else begin
              j <= j + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

/* sv/sor_pressure_poisson_solver_core.sv */
// Load: one beat per cycle while the result slot is free, result register loaded at the accept edge.
// Read: the pressure store read is registered, and the result beat is emitted from the read state, not at the accept.
// Solve: per sweep each relaxed cell takes five reads (cell and four neighbors) on one store port,
// then multiply, sum, multiply, write-back, accumulate; in red-black order the other color is
// skipped per pass; then the halo is copied and a serial division gives the mean residual.
// Reset: synchronous, active high; restores register defaults and clears status, stores kept.
module sor_pressure_poisson_solver_core import sorp_pkg::*; #(
  parameter int MAX_COLS = 62,
  parameter int MAX_ROWS = 62
) (
  input  logic                  clk,
  input  logic                  rst,
  sorp_job_if.sink              job,
  sorp_result_if.source         result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
`include "sor_pressure_poisson_solver_core_defines.svh"

  localparam int CW = $clog2(MAX_COLS + 2);
  localparam int RW = $clog2(MAX_ROWS + 2);

  cfg_t                     cfg;
  cmd_t                     cmd;
  sts_t                     sts;
  logic [CW-1:0]            nc, rcol, wcol;
  logic [RW-1:0]            nr, rrow, wrow;
  logic signed [DATA_W-1:0] dp_pressure;
  logic [ITER_W-1:0]        dp_iterations;
  logic [RES_W-1:0]         dp_residual;
  logic                     dp_converged;
  logic                     out_valid, slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_GRID_COLS:   cfg.grid_cols      <= cfg_data[SIZE_W-1:0];
        REG_GRID_ROWS:   cfg.grid_rows      <= cfg_data[SIZE_W-1:0];
        REG_MAX_ITER:    cfg.max_iterations <= cfg_data[ITER_W-1:0];
        REG_TOL_SQ:      cfg.tolerance_sq   <= cfg_data[RES_W-1:0];
        REG_RELAX:       cfg.relax_factor   <= cfg_data[COEF_W-1:0];
        REG_INV_DX_SQ:   cfg.inv_dx_sq      <= cfg_data[COEF_W-1:0];
        REG_INV_DY_SQ:   cfg.inv_dy_sq      <= cfg_data[COEF_W-1:0];
        REG_SWEEP_ORDER: cfg.sweep_order    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign slot_free = !out_valid || result.ready;

  sorp_ctrl #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (job.valid),
    .job_func  (job.func),
    .slot_free (slot_free),
    .job_ready (job.ready),
    .cmd       (cmd),
    .sts       (sts),
    .nc        (nc),
    .nr        (nr),
    .rcol      (rcol),
    .rrow      (rrow),
    .wcol      (wcol),
    .wrow      (wrow)
  );

  sorp_dp #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .sts          (sts),
    .nc           (nc),
    .nr           (nr),
    .rcol         (rcol),
    .rrow         (rrow),
    .wcol         (wcol),
    .wrow         (wrow),
    .ext_col      (job.col),
    .ext_row      (job.row),
    .ext_pressure (job.pressure_in),
    .ext_source   (job.source_in),
    .pressure_out (dp_pressure),
    .iterations   (dp_iterations),
    .residual     (dp_residual),
    .converged    (dp_converged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.pressure_out <= dp_pressure;
      result.iterations   <= dp_iterations;
      result.residual     <= dp_residual;
      result.converged    <= dp_converged;
    end
  end

  assign result.valid = out_valid;

  `SORP_ASSERT_IMPLY(a_ready_needs_slot, job.ready, !result.valid || result.ready, "job taken with result slot busy")
  `SORP_ASSERT_IMPLY(a_emit_needs_slot, cmd.emit, !result.valid || result.ready, "result beat overwritten")
  `SORP_ASSERT_NEXT(a_solve_blocks, job.valid && job.ready && job.func == FUNC_SOLVE, !job.ready, "job taken during solve")
endmodule

/* dv/sor_solve_checker.sv */
// Checker for the SOR pressure solver core: watches job, result and register ports,
// predicts each result from its own copy of the grids and registers, and compares.
// Depends on sorp_pkg and the channel interfaces in sorp_if.sv.
`timescale 1ns / 100ps

module sor_solve_checker import sorp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  sorp_job_if    job,
  sorp_result_if result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int     pending,
  output int     fails
);

  localparam int STRIDE = 64;
  localparam logic [63:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic signed [31:0] pressure;
    logic [15:0]        iterations;
    logic [62:0]        residual;
    logic               converged;
  } outcome_t;

  logic signed [31:0] p_grid [STRIDE*STRIDE];
  logic signed [31:0] s_grid [STRIDE*STRIDE];
  cfg_t        regs;
  logic [15:0] last_sweeps;
  logic [62:0] last_residual;
  logic        last_converged;
  outcome_t    expected_outcomes [$];

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint scale_q16(longint a, longint coef);
    return clamp32((clamp32(a) * coef) >>> 16);
  endfunction

  function automatic logic [63:0] relax_point(int i, int j);
    int c;
    longint pc, dx, dy, lap, r;
    c = j * STRIDE + i;
    pc = longint'(p_grid[c]);
    dx = longint'(p_grid[c+1]) - 2 * pc + longint'(p_grid[c-1]);
    dy = longint'(p_grid[c+STRIDE]) - 2 * pc + longint'(p_grid[c-STRIDE]);
    lap = clamp32(scale_q16(dx, longint'(regs.inv_dx_sq)) +
                  scale_q16(dy, longint'(regs.inv_dy_sq)));
    r = clamp32(longint'(s_grid[c]) - lap);
    p_grid[c] = clamp32(pc - scale_q16(r, longint'(regs.relax_factor)));
    return 64'(r * r);
  endfunction

  function automatic void run_sweeps();
    int nc, nr;
    logic [63:0] res, sum, sq, it;
    nc = (regs.grid_cols == 0) ? 1 : (regs.grid_cols > 62 ? 62 : int'(regs.grid_cols));
    nr = (regs.grid_rows == 0) ? 1 : (regs.grid_rows > 62 ? 62 : int'(regs.grid_rows));
    res = 64'h1_0000_0000;
    it = 0;
    while (res >= {1'b0, regs.tolerance_sq} && it < 64'(regs.max_iterations)) begin
      sum = 0;
      for (int pass = 0; pass < 2; pass++) begin
        if (pass == 1 && !regs.sweep_order) break;
        for (int j = 1; j <= nr; j++) begin
          for (int i = 1; i <= nc; i++) begin
            if (regs.sweep_order && ((i + j) % 2) != pass) continue;
            sq = relax_point(i, j);
            sum = (sum > SUM_MAX - sq) ? SUM_MAX : sum + sq;
          end
        end
      end
      for (int i = 1; i <= nc; i++) begin
        p_grid[i] = p_grid[STRIDE + i];
        p_grid[(nr + 1) * STRIDE + i] = p_grid[nr * STRIDE + i];
      end
      for (int j = 1; j <= nr; j++) begin
        p_grid[j * STRIDE] = p_grid[j * STRIDE + 1];
        p_grid[j * STRIDE + nc + 1] = p_grid[j * STRIDE + nc];
      end
      res = sum / 64'(nc * nr);
      it++;
    end
    last_sweeps = it[15:0];
    last_residual = res[62:0];
    last_converged = (res < {1'b0, regs.tolerance_sq});
  endfunction

  always @(posedge clk) begin
    outcome_t o, e;
    int addr;
    if (rst) begin
      regs = CFG_RESET;
      last_sweeps = '0;
      last_residual = '0;
      last_converged = 1'b0;
      expected_outcomes.delete();
      fails <= 0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_outcomes.size() == 0) begin
          if (fails < 10) $display("unexpected result beat: p=%h it=%0d res=%h conv=%b",
                                   result.pressure_out, result.iterations,
                                   result.residual, result.converged);
          fails <= fails + 1;
        end else begin
          e = expected_outcomes.pop_front();
          if (result.pressure_out !== e.pressure || result.iterations !== e.iterations ||
              result.residual !== e.residual || result.converged !== e.converged) begin
            if (fails < 10) begin
              $display("mismatch exp: p=%h it=%0d res=%h conv=%b", e.pressure,
                       e.iterations, e.residual, e.converged);
              $display("         got: p=%h it=%0d res=%h conv=%b", result.pressure_out,
                       result.iterations, result.residual, result.converged);
            end
            fails <= fails + 1;
          end
        end
      end
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_GRID_COLS:   regs.grid_cols = cfg_data[5:0];
          REG_GRID_ROWS:   regs.grid_rows = cfg_data[5:0];
          REG_MAX_ITER:    regs.max_iterations = cfg_data[15:0];
          REG_TOL_SQ:      regs.tolerance_sq = cfg_data[62:0];
          REG_RELAX:       regs.relax_factor = cfg_data[30:0];
          REG_INV_DX_SQ:   regs.inv_dx_sq = cfg_data[30:0];
          REG_INV_DY_SQ:   regs.inv_dy_sq = cfg_data[30:0];
          REG_SWEEP_ORDER: regs.sweep_order = cfg_data[0];
          default: ;
        endcase
      end
      if (job.valid && job.ready) begin
        addr = int'(job.row) * STRIDE + int'(job.col);
        o.pressure = '0;
        case (func_t'(job.func))
          FUNC_LOAD: begin
            p_grid[addr] = job.pressure_in;
            s_grid[addr] = job.source_in;
          end
          FUNC_SOLVE: run_sweeps();
          FUNC_READ:  o.pressure = p_grid[addr];
          default: ;
        endcase
        o.iterations = last_sweeps;
        o.residual = last_residual;
        o.converged = last_converged;
        expected_outcomes.push_back(o);
      end
    end
    pending <= expected_outcomes.size();
  end

endmodule

/* dv/testbench.sv */
// Top of the SOR solver core testbench: clock, reset, register writes and job stimulus
// with random idling on both channels; the checker instance does all comparing.
// Depends on sorp_pkg, sorp_if.sv, the core and sor_solve_checker.
`timescale 1ns / 100ps

module testbench;
  import sorp_pkg::*;

  localparam int LIMIT = 3_000_000;
  localparam int RANDOM_ITEMS = 1400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int pending, fails;
  int cycles = 0;
  int sent = 0;
  int tx_idle = 13, rx_idle = 56;
  bit loaded [4096];
  int loaded_q [$];

  sorp_job_if    job_ch ();
  sorp_result_if res_ch ();

  initial begin
    job_ch.valid = 1'b0;
    job_ch.func = FUNC_NOP;
    job_ch.col = '0;
    job_ch.row = '0;
    job_ch.pressure_in = '0;
    job_ch.source_in = '0;
    res_ch.ready = 1'b0;
  end

  sor_pressure_poisson_solver_core DUT (
    .clk(clk), .rst(rst), .job(job_ch.sink), .result(res_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sor_solve_checker checker_i (
    .clk(clk), .rst(rst), .job(job_ch), .result(res_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .fails(fails)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= rx_idle);
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic send(func_t f, int c, int r, logic [31:0] p, logic [31:0] s);
    if ($urandom_range(99) < tx_idle) begin
      job_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    job_ch.func <= f;
    job_ch.col <= c[5:0];
    job_ch.row <= r[5:0];
    job_ch.pressure_in <= p;
    job_ch.source_in <= s;
    job_ch.valid <= 1'b1;
    do @(posedge clk); while (!job_ch.ready);
    if (f == FUNC_LOAD && !loaded[r * 64 + c]) begin
      loaded[r * 64 + c] = 1'b1;
      loaded_q.push_back(r * 64 + c);
    end
    sent++;
    if (sent > 2 * RANDOM_ITEMS / 3) begin
      tx_idle = 0;
      rx_idle = 0;
    end else if (sent > RANDOM_ITEMS / 3) begin
      tx_idle = 56;
      rx_idle = 13;
    end
  endtask

  task automatic drain();
    job_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_cfg(cfg_t c);
    logic [CFG_DATA_W-1:0] vals [8];
    vals = '{63'(c.grid_cols), 63'(c.grid_rows), 63'(c.max_iterations), c.tolerance_sq,
             63'(c.relax_factor), 63'(c.inv_dx_sq), 63'(c.inv_dy_sq), 63'(c.sweep_order)};
    for (int k = 0; k < 8; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= k[CFG_IDX_W-1:0];
      cfg_data <= vals[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(262143)) - 131072);
      default: return 32'($signed($urandom_range(2047)) - 1024);
    endcase
  endfunction

  function automatic logic [30:0] rand_coef();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 31'($urandom_range(131072));
      default: return 31'($urandom_range(16384, 70000));
    endcase
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.grid_cols = $urandom_range(0, 5);
    c.grid_rows = $urandom_range(0, 5);
    c.max_iterations = $urandom_range(0, 6);
    case ($urandom_range(4))
      0: c.tolerance_sq = '0;
      1: c.tolerance_sq = {$urandom, $urandom};
      2: c.tolerance_sq = 63'h1_0000_0000 + $urandom_range(1) - 1;
      default: c.tolerance_sq = {$urandom_range(255), $urandom};
    endcase
    c.relax_factor = rand_coef();
    c.inv_dx_sq = rand_coef();
    c.inv_dy_sq = rand_coef();
    c.sweep_order = $urandom_range(1);
    return c;
  endfunction

  function automatic int eff(logic [5:0] v);
    return (v == 0) ? 1 : (v > 62 ? 62 : int'(v));
  endfunction

  task automatic load_grid(cfg_t c);
    int nc, nr;
    nc = eff(c.grid_cols);
    nr = eff(c.grid_rows);
    for (int r = 0; r <= nr + 1; r++) begin
      for (int k = 0; k <= nc + 1; k++) begin
        if ((r == 0 || r == nr + 1) && (k == 0 || k == nc + 1)) continue;
        send(FUNC_LOAD, k, r, rand_value(), rand_value());
      end
    end
  endtask

  task automatic read_some(int n);
    int a;
    repeat (n) begin
      a = loaded_q[$urandom_range(loaded_q.size() - 1)];
      send(FUNC_READ, a % 64, a / 64, $urandom, $urandom);
    end
  endtask

  task automatic episode(cfg_t c, int extra);
    drain();
    set_cfg(c);
    load_grid(c);
    repeat (extra) begin
      case ($urandom_range(5))
        0, 1: send(FUNC_LOAD, $urandom_range(63), $urandom_range(63), $urandom, $urandom);
        2: send(FUNC_NOP, $urandom_range(63), $urandom_range(63), $urandom, $urandom);
        default: read_some(1);
      endcase
    end
    send(FUNC_SOLVE, $urandom_range(63), $urandom_range(63), $urandom, $urandom);
    read_some($urandom_range(2, 6));
    if ($urandom_range(3) == 0) begin
      send(FUNC_SOLVE, 0, 0, 0, 0);
      read_some(2);
    end
  endtask

  initial begin
    cfg_t c;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: 1x1 grid from zero sizes, saturating coefficients and values
    c = '{grid_cols: 6'd0, grid_rows: 6'd0, max_iterations: 16'd3, tolerance_sq: '0,
          relax_factor: 31'h7FFF_FFFF, inv_dx_sq: 31'h7FFF_FFFF, inv_dy_sq: 31'h7FFF_FFFF,
          sweep_order: 1'b1};
    set_cfg(c);
    send(FUNC_LOAD, 1, 1, 32'h7FFF_FFFF, 32'h8000_0000);
    send(FUNC_LOAD, 0, 1, 32'h8000_0000, 32'h7FFF_FFFF);
    send(FUNC_LOAD, 2, 1, 32'h8000_0000, 32'h0);
    send(FUNC_LOAD, 1, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send(FUNC_LOAD, 1, 2, 32'h0, 32'h0);
    send(FUNC_LOAD, 63, 63, 32'h8000_0001, 32'h7FFF_FFFF);
    send(FUNC_READ, 63, 63, 32'h0, 32'h0);
    send(FUNC_NOP, 63, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(FUNC_SOLVE, 0, 0, 0, 0);
    send(FUNC_READ, 1, 1, 0, 0);
    send(FUNC_READ, 0, 1, 0, 0);
    send(FUNC_READ, 1, 2, 0, 0);
    // no sweep allowed and tolerance at one: nothing runs, not converged
    drain();
    c.max_iterations = '0;
    c.tolerance_sq = 63'h1_0000_0000;
    c.sweep_order = 1'b0;
    set_cfg(c);
    send(FUNC_SOLVE, 0, 0, 0, 0);
    // tolerance already above the start value: converged with no sweep
    drain();
    c.max_iterations = 16'hFFFF;
    c.tolerance_sq = '1;
    set_cfg(c);
    send(FUNC_SOLVE, 0, 0, 0, 0);
    send(FUNC_READ, 1, 1, 0, 0);
    // oversized column and row counts clamp to the maximum
    c = rand_cfg();
    c.grid_cols = 6'd63;
    c.grid_rows = 6'd1;
    c.max_iterations = 16'd2;
    episode(c, 2);
    c = rand_cfg();
    c.grid_cols = 6'd1;
    c.grid_rows = 6'd63;
    c.max_iterations = 16'd2;
    c.sweep_order = 1'b1;
    episode(c, 2);

    while (sent < RANDOM_ITEMS) begin
      c = rand_cfg();
      if ($urandom_range(7) == 0) c.max_iterations = $urandom_range(10, 40);
      episode(c, $urandom_range(0, 12));
    end

    drain();
    repeat (20) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
